### sv/tcavg_pkg.sv
// Shared types and constants for the thermocouple reading averager.
// Field widths, fault codes, controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package tcavg_pkg;

	// Field widths
	localparam int TEMP_W  = 17;
	localparam int OFS_W   = 15;
	localparam int FAULT_W = 3;
	localparam int ADJ_W   = 18;
	localparam int LAT_W   = 18;
	localparam int SUM_W   = 34;
	localparam int CNT_W   = 16;
	localparam int ERR_W   = 16;
	localparam int STEP_W  = $clog2(SUM_W);

	// Packed word widths on the stream ports
	localparam int IN_W  = 24;
	localparam int OUT_W = 56;

	// Limits
	localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [ERR_W-1:0] ERRORS_MAX = 16'hFFFF;

	localparam int HISTORY_DEPTH_DEF = 10;

	// Converter fault codes that reject a sample
	localparam logic [FAULT_W-1:0] FAULT_OPEN       = 3'd1;
	localparam logic [FAULT_W-1:0] FAULT_SHORT_GND  = 3'd2;
	localparam logic [FAULT_W-1:0] FAULT_SHORT_VCC  = 3'd4;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FETCH  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;      // input word taken this cycle
		logic start_mean;  // load divider with sum / count
		logic take_mean;   // capture mean as latest, clear accumulator
		logic hist_rd;     // read history entry at the pointer
		logic hist_wr;     // replace entry, update ring sum, advance pointer
		logic start_havg;  // register sign and magnitude of the ring sum
		logic take_havg;   // scale by the depth reciprocal, capture history average
		logic out_load;    // load output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_fetch;
		logic have_count;
		logic div_done;
	} stat_t;

endpackage

`default_nettype wire

### sv/thermocouple_reading_averager_core.sv
// Thermocouple reading averager, top level: stream ports, offset register.
// Instantiates tcavg_ctrl and tcavg_dp; depends on tcavg_pkg.
`default_nettype none

// One word in, one word out. A sample word adds the calibration offset, is
// screened (NaN, single fault bit, zero value) and goes into the running sum;
// its result is loaded into the output register once that register is free,
// and only then is the next word accepted. A fetch word runs the
// one-bit-per-cycle divider for its 34 steps to form the mean of the
// accumulated samples (skipped when no sample was taken), then reads and
// writes the ring and scales the ring sum by a reciprocal of the depth, with
// sign and magnitude registered first, before its result is loaded. A result
// not yet taken by the receiver holds back the load of the next one. One word
// is in flight at a time; the output register holds a result until it is
// taken, and a new word is accepted meanwhile. The history ring reads as zero
// after reset through per-entry valid bits, so no clearing pass. Write the
// offset only while no word is being worked on.
module thermocouple_reading_averager_core import tcavg_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [OFS_W-1:0] cfg_wdata,  // offset
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,    // temp_raw, fault_code, not_a_number, zero pad
	input  wire logic             s_tuser,    // kind
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata     // latest, history_average, error_count,
	                                          // last_fault, sample_dropped
);

	cmd_t  cmd;
	stat_t stat;

	tcavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcavg_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output word overwritten before it was taken");

	// Divider finishes only while an item is being worked on
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !s_tready)
		else $error("divider finished while idle");

	// Ring write follows its read
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_wr |-> $past(cmd.hist_rd))
		else $error("history write without preceding read");

	// At most one sequencing command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start_mean, cmd.start_havg, cmd.hist_rd, cmd.hist_wr,
			cmd.out_load}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

### sv/tcavg_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. Depends on tcavg_pkg.
`default_nettype none

module tcavg_div import tcavg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0]        divisor,
	output logic                         done,
	output logic [LAT_W-1:0]             quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W:0]    trial;
	logic              fits;
	logic [SUM_W-1:0]  signed_quo;

	// Shift one dividend bit into the partial remainder and try to subtract
	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Magnitude, remainder and sign
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? (-dividend) : dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], fits};
		end
	end

	// Restore the sign; the quotient always fits the reading width
	assign signed_quo = neg_q ? (-mag_q) : mag_q;
	assign quotient   = signed_quo[LAT_W-1:0];
	assign done       = done_q;

endmodule

`default_nettype wire

### sv/tcavg_dp.sv
// Datapath: offset, sample screening, accumulator, history ring, output word.
// Depends on tcavg_pkg and tcavg_div.
`default_nettype none

module tcavg_dp import tcavg_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [OFS_W-1:0] cfg_wdata,
	input  wire logic [IN_W-1:0]  in_data,
	input  wire logic             in_kind,
	input  wire cmd_t             cmd,
	output stat_t                 stat,
	output logic [OUT_W-1:0]      out_data
);

	localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HSUM_W = LAT_W + $clog2(HISTORY_DEPTH);

	// Ring average by reciprocal multiplication: exact floor for any ring sum magnitude
	localparam int HAVG_SHIFT = HSUM_W + $clog2(HISTORY_DEPTH);
	localparam int RECIP_W    = HSUM_W + 2;
	localparam int HPROD_W    = HSUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] HAVG_RECIP = RECIP_W'(((64'd1 << HAVG_SHIFT)
		+ 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

	logic signed [OFS_W-1:0]  offset_q;
	logic signed [SUM_W-1:0]  acc_sum_q;
	logic [CNT_W-1:0]         acc_count_q;
	logic signed [LAT_W-1:0]  latest_q;
	logic signed [LAT_W-1:0]  havg_q;
	logic [ERR_W-1:0]         errors_q;
	logic [FAULT_W-1:0]       fault_q;
	logic                     dropped_q;
	logic [PTR_W-1:0]         ptr_q;
	logic signed [HSUM_W-1:0] hsum_q;
	logic [HSUM_W-1:0]        hmag_s1;
	logic                     hneg_s1;
	logic [OUT_W-1:0]         out_q;

	logic [LAT_W-1:0]         hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic [LAT_W-1:0]         rd_data_s1;
	logic                     rd_vld_s1;

	logic signed [TEMP_W-1:0] temp_raw;
	logic [FAULT_W-1:0]       fault_code;
	logic                     not_a_number;
	logic signed [ADJ_W-1:0]  adj;
	logic                     reject;
	logic                     full;
	logic signed [LAT_W-1:0]  old_entry;
	logic [HPROD_W-1:0]       hprod;
	logic [LAT_W-1:0]         hquo;
	logic                     div_start;
	logic signed [SUM_W-1:0]  div_dividend;
	logic [CNT_W-1:0]         div_divisor;
	logic                     div_done;
	logic [LAT_W-1:0]         div_quo;

	// Unpack the input word
	assign temp_raw     = in_data[TEMP_W-1:0];
	assign fault_code   = in_data[TEMP_W +: FAULT_W];
	assign not_a_number = in_data[TEMP_W + FAULT_W];

	// Screen the sample
	assign adj    = ADJ_W'(temp_raw) + ADJ_W'(offset_q);
	assign reject = not_a_number || (fault_code == FAULT_OPEN)
		|| (fault_code == FAULT_SHORT_GND) || (fault_code == FAULT_SHORT_VCC)
		|| (adj == '0);
	assign full   = (acc_count_q >= COUNT_MAX);

	// Calibration offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// Accumulator, error count, fault, latest reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sum_q   <= '0;
			acc_count_q <= '0;
			latest_q    <= '0;
			errors_q    <= '0;
			fault_q     <= '0;
			dropped_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				dropped_q <= 1'b0;
				if (in_kind == KIND_SAMPLE) begin
					fault_q <= fault_code;
					if (reject) begin
						if (errors_q != ERRORS_MAX) begin
							errors_q <= errors_q + 1'b1;
						end
					end else if (full) begin
						dropped_q <= 1'b1;
					end else begin
						acc_sum_q   <= acc_sum_q + SUM_W'(adj);
						acc_count_q <= acc_count_q + 1'b1;
					end
				end
			end
			if (cmd.take_mean) begin
				latest_q    <= div_quo;
				acc_sum_q   <= '0;
				acc_count_q <= '0;
			end
		end
	end

	// History ring storage, read registered
	always_ff @(posedge clk) begin
		if (cmd.hist_rd) begin
			rd_data_s1 <= hist_mem[ptr_q];
		end
		if (cmd.hist_wr) begin
			hist_mem[ptr_q] <= latest_q;
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cmd.hist_rd) begin
				rd_vld_s1 <= hist_vld_q[ptr_q];
			end
			if (cmd.hist_wr) begin
				hist_vld_q[ptr_q] <= 1'b1;
			end
		end
	end

	assign old_entry = rd_vld_s1 ? rd_data_s1 : '0;

	// Scale the ring sum magnitude by the depth reciprocal
	assign hprod = hmag_s1 * HAVG_RECIP;
	assign hquo  = hprod[HAVG_SHIFT +: LAT_W];

	// Ring sum, pointer, history average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			hsum_q  <= '0;
			havg_q  <= '0;
			hmag_s1 <= '0;
			hneg_s1 <= 1'b0;
		end else begin
			if (cmd.hist_wr) begin
				hsum_q <= hsum_q - HSUM_W'(old_entry) + HSUM_W'(latest_q);
				if (ptr_q == PTR_W'(HISTORY_DEPTH - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.start_havg) begin
				hneg_s1 <= hsum_q[HSUM_W-1];
				hmag_s1 <= hsum_q[HSUM_W-1] ? -hsum_q : hsum_q;
			end
			if (cmd.take_havg) begin
				havg_q <= hneg_s1 ? -hquo : hquo;
			end
		end
	end

	// Divider: mean of the accumulated samples
	assign div_start    = cmd.start_mean;
	assign div_dividend = acc_sum_q;
	assign div_divisor  = acc_count_q;

	tcavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Output word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {dropped_q, fault_q, errors_q, havg_q, latest_q};
		end
	end

	assign out_data        = out_q;
	assign stat.is_fetch   = (in_kind == KIND_FETCH);
	assign stat.have_count = (acc_count_q != '0);
	assign stat.div_done   = div_done;

endmodule

`default_nettype wire

### sv/tcavg_ctrl.sv
// Controller: sequences one item through accumulate, divide and history update.
// Owns the stream handshakes. Depends on tcavg_pkg.
`default_nettype none

module tcavg_ctrl import tcavg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_QDIV  = 8'b0000_0010,
		ST_QWAIT = 8'b0000_0100,
		ST_HRD   = 8'b0000_1000,
		ST_HWR   = 8'b0001_0000,
		ST_HDIV  = 8'b0010_0000,
		ST_HWAIT = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!stat.is_fetch) begin
						state_d = ST_DONE;
					end else if (stat.have_count) begin
						state_d = ST_QDIV;
					end else begin
						state_d = ST_HRD;
					end
				end
			end
			ST_QDIV: begin
				cmd.start_mean = 1'b1;
				state_d        = ST_QWAIT;
			end
			ST_QWAIT: begin
				if (stat.div_done) begin
					cmd.take_mean = 1'b1;
					state_d       = ST_HRD;
				end
			end
			ST_HRD: begin
				cmd.hist_rd = 1'b1;
				state_d     = ST_HWR;
			end
			ST_HWR: begin
				cmd.hist_wr = 1'b1;
				state_d     = ST_HDIV;
			end
			ST_HDIV: begin
				cmd.start_havg = 1'b1;
				state_d        = ST_HWAIT;
			end
			ST_HWAIT: begin
				cmd.take_havg = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### tb/thermocouple_reading_averager_core_tb.sv
// Self-checking testbench for thermocouple_reading_averager_core.
// A built-in predictor of the averager checks every result word; needs tcavg_pkg and the core.
`timescale 1ns / 1ps

module thermocouple_reading_averager_core_tb;
	import tcavg_pkg::*;

	localparam int HIST_DEPTH    = HISTORY_DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int SETTLE_CYCLES = 120;
	localparam int PRESSURE_HOLD = 400;
	localparam int PHASE_WORDS   = 159;
	localparam int PRINT_CAP     = 50;

	localparam logic [FAULT_W-1:0] FAULT_NONE = '0;

	typedef struct packed {
		logic [LAT_W-1:0]   latest;
		logic [LAT_W-1:0]   hist_avg;
		logic [ERR_W-1:0]   errors;
		logic [FAULT_W-1:0] fault;
		logic               dropped;
	} reading_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [OFS_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// Predictor state, mirrors the averager
	logic signed [OFS_W-1:0] offset_r   = '0;
	longint                  acc_sum    = 0;
	logic [CNT_W-1:0]        acc_cnt    = '0;
	longint                  latest_r   = 0;
	longint                  ring [HIST_DEPTH] = '{default: 0};
	int                      ring_ptr   = 0;
	logic [ERR_W-1:0]        err_cnt    = '0;
	logic [FAULT_W-1:0]      fault_r    = '0;

	reading_t predicted_readings[$];
	int       mismatches  = 0;
	int       cycle_count = 0;
	bit       gaps_on     = 1'b1;
	bit       stalls_on   = 1'b1;
	int       hold_req    = 0;
	int       hold_seen   = 0;
	int       rx_wait     = 0;

	thermocouple_reading_averager_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Advance the averager model by one accepted word and return its result
	function automatic reading_t average_word(logic kind, logic signed [TEMP_W-1:0] temp,
			logic [FAULT_W-1:0] fc, logic nan);
		reading_t r;
		longint   adj;
		longint   hsum;
		longint   havg;
		bit       bad;
		r = '0;
		if (kind == KIND_SAMPLE) begin
			adj = longint'(temp) + longint'(offset_r);
			bad = nan || fc == FAULT_OPEN || fc == FAULT_SHORT_GND || fc == FAULT_SHORT_VCC ||
				adj == 0;
			fault_r = fc;
			if (bad) begin
				if (err_cnt != ERRORS_MAX)
					err_cnt++;
			end else if (acc_cnt == COUNT_MAX) begin
				r.dropped = 1'b1;
			end else begin
				acc_sum += adj;
				acc_cnt++;
			end
		end else begin
			if (acc_cnt != 0) begin
				latest_r = acc_sum / longint'(acc_cnt);
				acc_sum  = 0;
				acc_cnt  = '0;
			end
			ring[ring_ptr] = latest_r;
			ring_ptr = (ring_ptr == HIST_DEPTH - 1) ? 0 : ring_ptr + 1;
		end
		hsum = 0;
		foreach (ring[i])
			hsum += ring[i];
		havg       = hsum / HIST_DEPTH;
		r.latest   = latest_r[LAT_W-1:0];
		r.hist_avg = havg[LAT_W-1:0];
		r.errors   = err_cnt;
		r.fault    = fault_r;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string field, longint predicted_v, longint seen_v);
		if (mismatches < PRINT_CAP)
			$display("tb: %0t mismatch in %s: predicted %0h, seen %0h", $realtime, field,
				predicted_v, seen_v);
		mismatches++;
	endtask

	// Receiver: random stalls, plus a long hold when a test asks for one
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			rx_wait   = PRESSURE_HOLD;
		end
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
			if (stalls_on)
				rx_wait = pick_gap();
		end
	end

	// Compare each result word against the oldest prediction
	always @(posedge clk) begin : check_results
		reading_t seen;
		reading_t predicted;
		if (arst_n && m_tvalid && m_tready) begin
			seen.latest   = m_tdata[LAT_W-1:0];
			seen.hist_avg = m_tdata[2*LAT_W-1:LAT_W];
			seen.errors   = m_tdata[2*LAT_W+ERR_W-1:2*LAT_W];
			seen.fault    = m_tdata[2*LAT_W+ERR_W+FAULT_W-1:2*LAT_W+ERR_W];
			seen.dropped  = m_tdata[2*LAT_W+ERR_W+FAULT_W];
			if (predicted_readings.size() == 0) begin
				report_mismatch("unexpected word", 0, longint'(m_tdata));
			end else begin
				predicted = predicted_readings.pop_front();
				if (seen.latest !== predicted.latest)
					report_mismatch("latest", predicted.latest, seen.latest);
				if (seen.hist_avg !== predicted.hist_avg)
					report_mismatch("history_average", predicted.hist_avg, seen.hist_avg);
				if (seen.errors !== predicted.errors)
					report_mismatch("error_count", predicted.errors, seen.errors);
				if (seen.fault !== predicted.fault)
					report_mismatch("last_fault", predicted.fault, seen.fault);
				if (seen.dropped !== predicted.dropped)
					report_mismatch("sample_dropped", predicted.dropped, seen.dropped);
			end
		end
	end

	// Offer one word, wait for the handshake, then maybe idle
	task automatic send_word(logic kind, int temp, int fc, logic nan);
		logic signed [TEMP_W-1:0] t;
		logic [FAULT_W-1:0]       f;
		int                       gap;
		t = temp[TEMP_W-1:0];
		f = fc[FAULT_W-1:0];
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_W - TEMP_W - FAULT_W - 1){1'b0}}, nan, f, t};
		do
			@(posedge clk);
		while (!s_tready);
		predicted_readings.push_back(average_word(kind, t, f, nan));
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid, wait for every result, then let the core settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (predicted_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[OFS_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		offset_r = value[OFS_W-1:0];
	endtask

	// Random word: extremes, zero-after-offset values, all fault codes, NaN
	task automatic send_random_word(int fetch_pct);
		logic kind;
		int   r;
		int   v;
		int   fc;
		logic nan;
		kind = ($urandom_range(0, 99) < fetch_pct) ? KIND_FETCH : KIND_SAMPLE;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: v = -16384;
				1: v = 65535;
				2: v = -1;
				default: v = 0;
			endcase
		end else if (r < 18) begin
			v = -int'(offset_r);
		end else begin
			v = int'($urandom_range(0, 81919)) - 16384;
		end
		fc  = $urandom_range(0, 1) ? int'(FAULT_NONE) : int'($urandom_range(0, 7));
		nan = ($urandom_range(0, 9) == 0);
		send_word(kind, v, fc, nan);
	endtask

	// Empty fetch, every fault code, NaN, zero value, mean rounding toward zero
	task automatic test_directed();
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, 65535, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, -16384, FAULT_OPEN | FAULT_SHORT_GND, 1'b0);
		send_word(KIND_SAMPLE, 100, FAULT_OPEN, 1'b0);
		send_word(KIND_SAMPLE, 100, FAULT_SHORT_GND, 1'b0);
		send_word(KIND_SAMPLE, 100, FAULT_SHORT_VCC, 1'b0);
		send_word(KIND_SAMPLE, 200, FAULT_OPEN | FAULT_SHORT_VCC, 1'b1);
		send_word(KIND_SAMPLE, 0, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, 300, FAULT_SHORT_GND | FAULT_SHORT_VCC, 1'b0);
		send_word(KIND_SAMPLE, 400, FAULT_OPEN | FAULT_SHORT_GND | FAULT_SHORT_VCC, 1'b0);
		send_word(KIND_FETCH, -1, FAULT_OPEN, 1'b1);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, -1, FAULT_NONE, 1'b0);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, -3, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, 2, FAULT_NONE, 1'b0);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		wait_idle();
	endtask

	// Offset extremes: largest and smallest adjusted values, offset cancelling the sample
	task automatic test_offset_extremes();
		write_offset(16383);
		send_word(KIND_SAMPLE, 65535, FAULT_NONE, 1'b0);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		wait_idle();
		write_offset(-16384);
		send_word(KIND_SAMPLE, -16384, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, 16384, FAULT_NONE, 1'b0);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		wait_idle();
		write_offset(-1);
		send_word(KIND_SAMPLE, 1, FAULT_NONE, 1'b0);
		send_word(KIND_SAMPLE, -16384, FAULT_NONE, 1'b0);
		send_word(KIND_FETCH, 0, FAULT_NONE, 1'b0);
		wait_idle();
	endtask

	// Random words over several offset settings
	task automatic test_random();
		int offsets [5];
		offsets = '{16383, -16384, 0, 0, 0};
		offsets[2] = int'($urandom_range(0, 32767)) - 16384;
		offsets[3] = int'($urandom_range(0, 32767)) - 16384;
		foreach (offsets[p]) begin
			write_offset(offsets[p]);
			repeat (PHASE_WORDS) send_random_word(15);
			wait_idle();
		end
	endtask

	// Hold the receiver off while words keep coming, so the input backs up
	task automatic test_pressure();
		gaps_on = 1'b0;
		hold_req++;
		repeat (30) send_random_word(20);
		gaps_on = 1'b1;
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_offset_extremes();
		test_random();
		test_pressure();
		wait_idle();
		if (mismatches == 0 && predicted_readings.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
